@@ rtl/core/dprsc_pkg.sv @@
// ----------------------------------------------------------------------------
// dprsc_pkg
// Shared types, widths and register codes for the dual-pixel sub-frame combiner.
// ----------------------------------------------------------------------------
package dprsc_pkg;

  // Sample and fixed-point formats
  localparam int unsigned SAMPLE_BITS     = 16;
  localparam int unsigned BLACK_BITS      = 16;   // U12.4
  localparam int unsigned FRAC_BITS       = 4;    // fraction bits of a black level
  localparam int unsigned SCALE_BITS      = 16;   // U6.10
  localparam int unsigned SCALE_FRAC_BITS = 10;
  localparam int unsigned NUM_CHAN        = 4;

  localparam int unsigned BLACK_PACK_BITS = NUM_CHAN * BLACK_BITS;
  localparam int unsigned CFG_DATA_BITS   = 64;
  localparam int unsigned CFG_INDEX_BITS  = 3;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BLACK_SUMMED  = 3'd0,
    REG_BLACK_SECOND  = 3'd1,
    REG_WHITE_LEVEL   = 3'd2,
    REG_EXPOSURE_SCL  = 3'd3,
    REG_OPERATION     = 3'd4,
    REG_DECISION_MODE = 3'd5
  } cfg_index_e;

  typedef enum logic {
    OP_EXTRACT = 1'b0,
    OP_BLEND   = 1'b1
  } operation_e;

  typedef enum logic {
    MODE_PLAIN = 1'b0,
    MODE_BAYER = 1'b1
  } decision_e;

  localparam logic [BLACK_PACK_BITS-1:0] BLACK_RESET = '0;
  localparam logic [SAMPLE_BITS-1:0]     WHITE_RESET = '1;
  localparam logic [SCALE_BITS-1:0]      SCALE_RESET = SCALE_BITS'(1 << SCALE_FRAC_BITS);

  typedef struct packed {
    logic [BLACK_PACK_BITS-1:0] black_summed;
    logic [BLACK_PACK_BITS-1:0] black_second;
    logic [SAMPLE_BITS-1:0]     white_level;
    logic [SCALE_BITS-1:0]      exposure_scale;
    operation_e                 operation;
    decision_e                  decision_mode;
  } cfg_t;

  // Per-lane control shared by all four channels
  typedef struct packed {
    operation_e             operation;
    decision_e              decision_mode;
    logic [SAMPLE_BITS-1:0] white_level;
    logic [SCALE_BITS-1:0]  exposure_scale;
  } lane_ctrl_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sum_red;
    logic [SAMPLE_BITS-1:0] sum_green_one;
    logic [SAMPLE_BITS-1:0] sum_green_two;
    logic [SAMPLE_BITS-1:0] sum_blue;
    logic [SAMPLE_BITS-1:0] sub_red;
    logic [SAMPLE_BITS-1:0] sub_green_one;
    logic [SAMPLE_BITS-1:0] sub_green_two;
    logic [SAMPLE_BITS-1:0] sub_blue;
  } quad_in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] out_red;
    logic [SAMPLE_BITS-1:0] out_green_one;
    logic [SAMPLE_BITS-1:0] out_green_two;
    logic [SAMPLE_BITS-1:0] out_blue;
  } quad_out_t;

endpackage

@@ rtl/core/dprsc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dprsc_cfg_regs
// Configuration register file; writes with an unknown index are dropped.
// ----------------------------------------------------------------------------
module dprsc_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dprsc_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [dprsc_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output dprsc_pkg::cfg_t                      cfg_o
);
  import dprsc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BLACK_SUMMED:  cfg_d.black_summed   = cfg_data_i[BLACK_PACK_BITS-1:0];
        REG_BLACK_SECOND:  cfg_d.black_second   = cfg_data_i[BLACK_PACK_BITS-1:0];
        REG_WHITE_LEVEL:   cfg_d.white_level    = cfg_data_i[SAMPLE_BITS-1:0];
        REG_EXPOSURE_SCL:  cfg_d.exposure_scale = cfg_data_i[SCALE_BITS-1:0];
        REG_OPERATION:     cfg_d.operation      = operation_e'(cfg_data_i[0]);
        REG_DECISION_MODE: cfg_d.decision_mode  = decision_e'(cfg_data_i[0]);
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.black_summed   <= BLACK_RESET;
      cfg_q.black_second   <= BLACK_RESET;
      cfg_q.white_level    <= WHITE_RESET;
      cfg_q.exposure_scale <= SCALE_RESET;
      cfg_q.operation      <= OP_EXTRACT;
      cfg_q.decision_mode  <= MODE_PLAIN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/dprsc_lane.sv @@
// ----------------------------------------------------------------------------
// dprsc_lane
// One color channel: A-extract and blend arithmetic, rounding, saturation,
// and substitution of clipped samples.
// ----------------------------------------------------------------------------
module dprsc_lane (
  input  logic [dprsc_pkg::SAMPLE_BITS-1:0] ab_i,
  input  logic [dprsc_pkg::SAMPLE_BITS-1:0] b_i,
  input  logic [dprsc_pkg::BLACK_BITS-1:0]  black_ab_i,
  input  logic [dprsc_pkg::BLACK_BITS-1:0]  black_b_i,
  input  dprsc_pkg::lane_ctrl_t             ctrl_i,
  input  logic                              use_sub_i,
  output logic [dprsc_pkg::SAMPLE_BITS-1:0] result_o
);
  import dprsc_pkg::*;

  // Extract path in U.4: 16*AB - bAB - 16*B + 2*bB + half
  localparam int unsigned EXT_W    = SAMPLE_BITS + FRAC_BITS + 3;
  localparam int unsigned EXT_TOP  = SAMPLE_BITS + FRAC_BITS;
  // Blend path: (16*AB - bAB) * scale + bB * 2^F + half
  localparam int unsigned DIFF_W   = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int unsigned PROD_W   = DIFF_W + SCALE_BITS + 1;
  localparam int unsigned BLEND_W  = PROD_W + 2;
  localparam int unsigned BL_SHIFT = FRAC_BITS + SCALE_FRAC_BITS;
  localparam int unsigned BL_TOP   = SAMPLE_BITS + BL_SHIFT;

  localparam logic signed [EXT_W-1:0]   EXT_HALF   = EXT_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [BLEND_W-1:0] BLEND_HALF = BLEND_W'(1 << (BL_SHIFT - 1));
  localparam logic [SAMPLE_BITS-1:0]    SAMPLE_MAX = '1;

  logic signed [EXT_W-1:0]   ext_v;
  logic [SAMPLE_BITS-1:0]    ext_res;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod;
  logic signed [BLEND_W-1:0] blend_v;
  logic [SAMPLE_BITS-1:0]    blend_res;

  always_comb begin
    ext_v = $signed(EXT_W'({ab_i, {FRAC_BITS{1'b0}}}))
          - $signed(EXT_W'(black_ab_i))
          - $signed(EXT_W'({b_i, {FRAC_BITS{1'b0}}}))
          + $signed(EXT_W'({black_b_i, 1'b0}))
          + EXT_HALF;
    if (ext_v[EXT_W-1]) begin
      ext_res = '0;
    end else if (|ext_v[EXT_W-2:EXT_TOP]) begin
      ext_res = SAMPLE_MAX;
    end else begin
      ext_res = ext_v[EXT_TOP-1:FRAC_BITS];
    end
  end

  always_comb begin
    diff    = $signed(DIFF_W'({ab_i, {FRAC_BITS{1'b0}}})) - $signed(DIFF_W'(black_ab_i));
    prod    = diff * $signed({1'b0, ctrl_i.exposure_scale});
    blend_v = BLEND_W'(prod)
            + $signed(BLEND_W'({black_b_i, {SCALE_FRAC_BITS{1'b0}}}))
            + BLEND_HALF;
    if (blend_v[BLEND_W-1]) begin
      blend_res = '0;
    end else if (|blend_v[BLEND_W-2:BL_TOP]) begin
      blend_res = SAMPLE_MAX;
    end else begin
      blend_res = blend_v[BL_TOP-1:BL_SHIFT];
    end
  end

  always_comb begin
    if (use_sub_i) begin
      if (ctrl_i.operation == OP_EXTRACT && ctrl_i.decision_mode == MODE_BAYER) begin
        result_o = ctrl_i.white_level;
      end else begin
        result_o = b_i;
      end
    end else if (ctrl_i.operation == OP_EXTRACT) begin
      result_o = ext_res;
    end else begin
      result_o = blend_res;
    end
  end

endmodule

@@ rtl/core/dual_pixel_raw_subframe_combine_core.sv @@
// ----------------------------------------------------------------------------
// dual_pixel_raw_subframe_combine_core
// Combines one RGGB quad of a dual-pixel raw frame (A+B and B samples).
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive quad_i and raise start. A quad transfers at each rising edge
//   with start high and busy low. busy never rises, so one quad can transfer
//   in every cycle.
//   Output: done_o pulses for exactly one cycle with the combined quad on
//   result_o once the quad has passed the input register, then the four parallel
//   channel lanes, into the result register. Throughput is one quad per
//   clock, set by the combinational lane multiplier path.
//   The receiver has no stall: it must take result_o whenever done_o is high.
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i.
//   cfg_ready_o stays high; a transfer to an unknown index is dropped.
//   Write configuration only while no quad is in flight.
//   Reset: rst_ni clears the pipeline valids and loads register defaults
//   (black levels zero, white 65535, scale 1.0, extract, plain decision).
// ----------------------------------------------------------------------------
module dual_pixel_raw_subframe_combine_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  dprsc_pkg::quad_in_t                  quad_i,
  output logic                                 done_o,
  output dprsc_pkg::quad_out_t                 result_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dprsc_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [dprsc_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import dprsc_pkg::*;

  cfg_t       cfg;
  lane_ctrl_t lane_ctrl;

  logic       in_valid_q;
  quad_in_t   quad_q;
  logic       done_q;
  quad_out_t  result_q, result_d;

  logic [SAMPLE_BITS-1:0] ab     [NUM_CHAN];
  logic [SAMPLE_BITS-1:0] b      [NUM_CHAN];
  logic [SAMPLE_BITS-1:0] lane_y [NUM_CHAN];
  logic [NUM_CHAN-1:0]    clipped;
  logic                   any_clipped;

  // Never back-pressure the source
  assign busy = 1'b0;

  dprsc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input register: capture each transferred quad
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      quad_q <= quad_i;
    end
  end

  // Unpack in channel order red, g1, g2, blue
  always_comb begin
    ab[0] = quad_q.sum_red;
    ab[1] = quad_q.sum_green_one;
    ab[2] = quad_q.sum_green_two;
    ab[3] = quad_q.sum_blue;
    b[0]  = quad_q.sub_red;
    b[1]  = quad_q.sub_green_one;
    b[2]  = quad_q.sub_green_two;
    b[3]  = quad_q.sub_blue;
  end

  // Clip test: a summed sample at or above white counts as overexposed
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      clipped[c] = ab[c] >= cfg.white_level;
    end
    any_clipped = |clipped;
  end

  assign lane_ctrl = '{
    operation:      cfg.operation,
    decision_mode:  cfg.decision_mode,
    white_level:    cfg.white_level,
    exposure_scale: cfg.exposure_scale
  };

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    dprsc_lane u_lane (
      .ab_i       (ab[c]),
      .b_i        (b[c]),
      .black_ab_i (cfg.black_summed[c*BLACK_BITS +: BLACK_BITS]),
      .black_b_i  (cfg.black_second[c*BLACK_BITS +: BLACK_BITS]),
      .ctrl_i     (lane_ctrl),
      // Bayer mode substitutes the whole quad when any channel clips
      .use_sub_i  ((cfg.decision_mode == MODE_BAYER) ? any_clipped : clipped[c]),
      .result_o   (lane_y[c])
    );
  end

  always_comb begin
    result_d.out_red       = lane_y[0];
    result_d.out_green_one = lane_y[1];
    result_d.out_green_two = lane_y[2];
    result_d.out_blue      = lane_y[3];
  end

  // Result register: one-cycle strobe per quad
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

@@ rtl/core/dprsc_checker.sv @@
// ----------------------------------------------------------------------------
// dprsc_checker
// Port-level timing checks for the sub-frame combiner, bound to the top level.
// ----------------------------------------------------------------------------
module dprsc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic cfg_valid_i,
  input logic cfg_ready_o
);

  // Every transferred quad yields a strobe after the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("quad transfer without result strobe");

  // No strobe without a quad transferred ahead of it through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result strobe without a transferred quad");

  // Neither channel ever back-pressures
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && cfg_ready_o)
    else $error("unexpected back-pressure");

  // A pending configuration write is never stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind dual_pixel_raw_subframe_combine_core dprsc_checker u_dprsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

@@ test/dprsc_quad_checker.sv @@
// ----------------------------------------------------------------------------
// dprsc_quad_checker
// Scoreboard for the dual-pixel sub-frame combiner. Mirrors every register
// transfer, predicts the output quad of every accepted input quad and checks
// the results in arrival order.
// ----------------------------------------------------------------------------
module dprsc_quad_checker
  import dprsc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      quad_start_i,
  input  logic                      busy_i,
  input  quad_in_t                  quad_i,
  input  logic                      done_i,
  input  quad_out_t                 result_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i,
  output int unsigned               mismatch_count_o,
  output int unsigned               pending_quads_o
);

  // keep the log readable if the block is badly broken
  localparam int unsigned REPORT_LIMIT = 200;

  cfg_t        shadow_cfg;
  quad_out_t   expected_quads[$];
  quad_out_t   oldest;
  int unsigned mismatch_count = 0;
  int unsigned report_count   = 0;
  int unsigned pending_count  = 0;

  assign mismatch_count_o = mismatch_count;
  assign pending_quads_o  = pending_count;

  function automatic logic [SAMPLE_BITS-1:0] saturate_sample(input longint v);
    if (v < 0) return '0;
    if (v > (longint'(1) << SAMPLE_BITS) - 1) return '1;
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic quad_out_t combine_quad(input quad_in_t q, input cfg_t c);
    logic [SAMPLE_BITS-1:0] summed   [NUM_CHAN];
    logic [SAMPLE_BITS-1:0] second   [NUM_CHAN];
    logic [SAMPLE_BITS-1:0] combined [NUM_CHAN];
    logic                   clipped  [NUM_CHAN];
    logic                   any_clipped;
    logic                   take_second;
    longint                 black_sum;
    longint                 black_sub;
    longint                 acc;
    quad_out_t              r;
    summed = '{q.sum_red, q.sum_green_one, q.sum_green_two, q.sum_blue};
    second = '{q.sub_red, q.sub_green_one, q.sub_green_two, q.sub_blue};
    any_clipped = 1'b0;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      clipped[ch] = summed[ch] >= c.white_level;
      any_clipped |= clipped[ch];
    end
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      black_sum   = longint'(c.black_summed[BLACK_BITS*ch +: BLACK_BITS]);
      black_sub   = longint'(c.black_second[BLACK_BITS*ch +: BLACK_BITS]);
      take_second = (c.decision_mode == MODE_BAYER) ? any_clipped : clipped[ch];
      if (take_second && c.operation == OP_EXTRACT && c.decision_mode == MODE_BAYER) begin
        combined[ch] = saturate_sample(longint'(c.white_level));
      end else if (take_second) begin
        combined[ch] = second[ch];
      end else if (c.operation == OP_EXTRACT) begin
        // U.4: (AB - blackAB) - (B - blackB) + blackB, round half up
        acc = 16 * longint'(summed[ch]) - black_sum - 16 * longint'(second[ch])
              + 2 * black_sub + 8;
        combined[ch] = saturate_sample(acc >>> FRAC_BITS);
      end else begin
        // (AB - blackAB) * scale + blackB, with 4 + scale fraction bits
        acc = (16 * longint'(summed[ch]) - black_sum) * longint'(c.exposure_scale)
              + (black_sub << SCALE_FRAC_BITS)
              + (longint'(1) << (FRAC_BITS - 1 + SCALE_FRAC_BITS));
        combined[ch] = saturate_sample(acc >>> (FRAC_BITS + SCALE_FRAC_BITS));
      end
    end
    r.out_red       = combined[0];
    r.out_green_one = combined[1];
    r.out_green_two = combined[2];
    r.out_blue      = combined[3];
    return r;
  endfunction

  task automatic check_field(input string label, input logic [SAMPLE_BITS-1:0] want,
                             input logic [SAMPLE_BITS-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (report_count < REPORT_LIMIT) begin
        report_count++;
        $display("%0t: %s mismatch: expected 0x%h, actual 0x%h", $time, label, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_cfg.black_summed   = '0;
      shadow_cfg.black_second   = '0;
      shadow_cfg.white_level    = '1;
      shadow_cfg.exposure_scale = SCALE_BITS'(1 << SCALE_FRAC_BITS);
      shadow_cfg.operation      = OP_EXTRACT;
      shadow_cfg.decision_mode  = MODE_PLAIN;
      expected_quads.delete();
      pending_count = 0;
    end else begin
      // check results before taking new quads in
      if (done_i) begin
        if (expected_quads.size() == 0) begin
          mismatch_count++;
          if (report_count < REPORT_LIMIT) begin
            report_count++;
            $display("%0t: unexpected result: expected none, actual 0x%h", $time, result_i);
          end
        end else begin
          oldest = expected_quads.pop_front();
          check_field("out_red", oldest.out_red, result_i.out_red);
          check_field("out_green_one", oldest.out_green_one, result_i.out_green_one);
          check_field("out_green_two", oldest.out_green_two, result_i.out_green_two);
          check_field("out_blue", oldest.out_blue, result_i.out_blue);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_BLACK_SUMMED:  shadow_cfg.black_summed   = cfg_data_i[BLACK_PACK_BITS-1:0];
          REG_BLACK_SECOND:  shadow_cfg.black_second   = cfg_data_i[BLACK_PACK_BITS-1:0];
          REG_WHITE_LEVEL:   shadow_cfg.white_level    = cfg_data_i[SAMPLE_BITS-1:0];
          REG_EXPOSURE_SCL:  shadow_cfg.exposure_scale = cfg_data_i[SCALE_BITS-1:0];
          REG_OPERATION:     shadow_cfg.operation      = operation_e'(cfg_data_i[0]);
          REG_DECISION_MODE: shadow_cfg.decision_mode  = decision_e'(cfg_data_i[0]);
          default: ;
        endcase
      end
      if (quad_start_i && !busy_i) begin
        expected_quads.push_back(combine_quad(quad_i, shadow_cfg));
      end
      pending_count = expected_quads.size();
    end
  end

endmodule

@@ test/dual_pixel_raw_subframe_combine_core_test.sv @@
// ----------------------------------------------------------------------------
// dual_pixel_raw_subframe_combine_core_test
// Drives quads and register transfers into the sub-frame combiner: a short
// directed pass over the corner cases, then random phases with changing
// register settings and sender gaps. A checker module beside the block
// predicts and compares every result; this module only stimulates and
// gives the verdict.
// ----------------------------------------------------------------------------
module dual_pixel_raw_subframe_combine_core_test;
  import dprsc_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 6;
  localparam int SETTLE_CYCLES   = 8;     // result pipeline is two deep, leave margin
  localparam int STALL_LIMIT     = 4000;  // cycles without any transfer
  localparam int RANDOM_PHASES   = 12;
  localparam int QUADS_PER_PHASE = 104;

  // Indexes past the register map: transfers there must be dropped
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_SIX   = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_SEVEN = 3'd7;

  logic                      clk;
  logic                      rst_n;
  logic                      quad_start = 1'b0;
  logic                      busy;
  quad_in_t                  quad_data  = '0;
  logic                      done;
  quad_out_t                 result;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data   = '0;

  int unsigned mismatches;
  int unsigned pending_quads;
  int unsigned stall_cycles = 0;

  // White level currently loaded; random quads aim samples around it
  logic [SAMPLE_BITS-1:0] white_now = '1;

  // Sender idle chance per cycle, in percent, cycled over the random phases
  int idle_pct_by_phase [3] = '{0, 56, 14};

  dual_pixel_raw_subframe_combine_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (quad_start),
    .busy        (busy),
    .quad_i      (quad_data),
    .done_o      (done),
    .result_o    (result),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  dprsc_quad_checker u_quad_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .quad_start_i     (quad_start),
    .busy_i           (busy),
    .quad_i           (quad_data),
    .done_i           (done),
    .result_i         (result),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_quads_o  (pending_quads)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Watchdog: end the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((quad_start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("dual_pixel_raw_subframe_combine_core_test: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // All stimulus tasks enter and leave on a falling edge. Each drives a
  // signal at most once per edge, so valid/start that stay high for the
  // next transfer are never dropped and raised in the same time step.

  // Present one quad, optionally after a random gap, and hold it until
  // the block takes it.
  task automatic send_quad(input quad_in_t q, input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      quad_start <= 1'b0;
      quad_data  <= quad_in_t'({$urandom, $urandom, $urandom, $urandom});
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    quad_start <= 1'b1;
    quad_data  <= q;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drop start and hold off until every expected result has come back.
  // Always wait on a falling edge first so start is not driven twice in a step.
  task automatic wait_for_drain();
    quad_start <= 1'b0;
    do @(negedge clk); while (pending_quads != 0);
  endtask

  // One register transfer; leaves valid high for a following write.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Drain the block, then write all six registers. Unused upper data bits
  // carry noise to catch missing width masks; two writes to unmapped
  // indexes follow and must leave the settings alone.
  task automatic load_settings(input logic [CFG_DATA_BITS-1:0] black_sum,
                               input logic [CFG_DATA_BITS-1:0] black_sub,
                               input logic [SAMPLE_BITS-1:0]   white,
                               input logic [SCALE_BITS-1:0]    scale,
                               input operation_e               op,
                               input decision_e                mode);
    logic [CFG_DATA_BITS-1:0] noise;
    noise = {$urandom, $urandom};
    wait_for_drain();
    write_reg(REG_BLACK_SUMMED, black_sum);
    write_reg(REG_BLACK_SECOND, black_sub);
    write_reg(REG_WHITE_LEVEL, {noise[CFG_DATA_BITS-1:SAMPLE_BITS], white});
    write_reg(REG_EXPOSURE_SCL, {~noise[CFG_DATA_BITS-1:SCALE_BITS], scale});
    write_reg(REG_OPERATION, {noise[CFG_DATA_BITS-1:1], op});
    write_reg(REG_DECISION_MODE, {~noise[CFG_DATA_BITS-1:1], mode});
    write_reg(REG_SPARE_SIX, noise);
    write_reg(REG_SPARE_SEVEN, ~noise);
    cfg_valid <= 1'b0;
    white_now = white;
  endtask

  // Mostly plausible black levels (up to 1024 in U12.4), sometimes any value
  function automatic logic [CFG_DATA_BITS-1:0] pick_black_levels();
    logic [CFG_DATA_BITS-1:0] levels;
    if ($urandom_range(3) == 0) return {$urandom, $urandom};
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      levels[BLACK_BITS*ch +: BLACK_BITS] = BLACK_BITS'($urandom_range(1024 * 16));
    end
    return levels;
  endfunction

  task automatic load_random_settings(input int phase);
    logic [SAMPLE_BITS-1:0] white;
    logic [SCALE_BITS-1:0]  scale;
    case ($urandom_range(5))
      0:       white = '1;
      1:       white = SAMPLE_BITS'($urandom);
      default: white = SAMPLE_BITS'($urandom_range(65535, 40000));
    endcase
    case ($urandom_range(9))
      0, 1:    scale = SCALE_BITS'(1 << SCALE_FRAC_BITS);
      2:       scale = SCALE_BITS'(2 << SCALE_FRAC_BITS);
      3:       scale = SCALE_BITS'(1 << (SCALE_FRAC_BITS - 1));
      4:       scale = SCALE_BITS'(4 << SCALE_FRAC_BITS);
      5:       scale = '0;
      6:       scale = '1;
      default: scale = SCALE_BITS'($urandom);
    endcase
    // walk all four operation / decision pairs across the phases
    load_settings(pick_black_levels(), pick_black_levels(), white, scale,
                  operation_e'(phase[0]), decision_e'(phase[1]));
  endtask

  // Most quads look like real dual-pixel data: B close to half of A+B, with
  // summed samples often sitting right at the white level. The rest is noise.
  function automatic quad_in_t pick_quad();
    logic [SAMPLE_BITS-1:0] summed [NUM_CHAN];
    logic [SAMPLE_BITS-1:0] second [NUM_CHAN];
    logic                   plausible;
    plausible = $urandom_range(9) < 7;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      if (!plausible) begin
        summed[ch] = SAMPLE_BITS'($urandom);
        second[ch] = SAMPLE_BITS'($urandom);
      end else begin
        case ($urandom_range(7))
          0, 1:    summed[ch] = SAMPLE_BITS'(white_now - 1 + $urandom_range(2));
          2:       summed[ch] = '1;
          3:       summed[ch] = '0;
          default: summed[ch] = SAMPLE_BITS'($urandom);
        endcase
        second[ch] = SAMPLE_BITS'((summed[ch] >> 1) + $urandom_range(64) - 32);
      end
    end
    return quad_in_t'{summed[0], summed[1], summed[2], summed[3],
                      second[0], second[1], second[2], second[3]};
  endfunction

  function automatic quad_in_t uniform_quad(input logic [SAMPLE_BITS-1:0] sum_value,
                                            input logic [SAMPLE_BITS-1:0] sub_value);
    return quad_in_t'{sum_value, sum_value, sum_value, sum_value,
                      sub_value, sub_value, sub_value, sub_value};
  endfunction

  initial begin
    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: extract, per-channel test, white at full scale, no black.
    send_quad(uniform_quad(16'h0000, 16'h0000), 0);
    // every summed sample at white: pass the B samples through
    send_quad(uniform_quad(16'hFFFF, 16'h1234), 0);
    // B above A+B: negative difference floors at zero
    send_quad(uniform_quad(16'h0064, 16'h00C8), 0);
    send_quad(quad_in_t'{16'hFFFE, 16'h8000, 16'h7FFF, 16'h0001,
                         16'h0000, 16'hFFFF, 16'h7FFF, 16'h0001}, 0);

    // Blend at the largest scale with full B black: saturate high, black only
    load_settings('0, '1, '1, '1, OP_BLEND, MODE_PLAIN);
    send_quad(uniform_quad(16'hFFFE, 16'h0000), 0);
    send_quad(uniform_quad(16'h0000, 16'h5A5A), 0);
    send_quad(quad_in_t'{16'hFFFF, 16'h0000, 16'h7FFF, 16'h0001,
                         16'hA5A5, 16'h1111, 16'h2222, 16'h3333}, 0);

    // Blend, whole-quad test, full summed black: a single clip swaps in all of B
    load_settings('1, '0, 16'h8000, SCALE_BITS'(1 << SCALE_FRAC_BITS),
                  OP_BLEND, MODE_BAYER);
    send_quad(uniform_quad(16'h0100, 16'h3333), 0);
    send_quad(quad_in_t'{16'h8000, 16'h0000, 16'h0000, 16'h0000,
                         16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00}, 0);
    send_quad(uniform_quad(16'h7FFF, 16'hFFFF), 0);

    // Extract, whole-quad test: a single clip turns the quad white
    load_settings('0, '1, 16'h8000, '0, OP_EXTRACT, MODE_BAYER);
    send_quad(quad_in_t'{16'h0000, 16'h0000, 16'h0000, 16'h8000,
                         16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0}, 0);
    send_quad(uniform_quad(16'h7FFF, 16'h0000), 0);
    send_quad(uniform_quad(16'h7FFF, 16'hFFFF), 0);

    // White level zero: everything clips, the quad goes to zero
    load_settings({$urandom, $urandom}, {$urandom, $urandom}, '0,
                  SCALE_BITS'(1 << SCALE_FRAC_BITS), OP_EXTRACT, MODE_BAYER);
    send_quad(uniform_quad(16'h0000, 16'hFFFF), 0);
    send_quad(pick_quad(), 0);

    // Extract, per channel, full B black: overflow saturates at the maximum
    load_settings('0, '1, '1, SCALE_BITS'(1 << SCALE_FRAC_BITS), OP_EXTRACT, MODE_PLAIN);
    send_quad(uniform_quad(16'hFFFE, 16'h0000), 0);
    send_quad(quad_in_t'{16'hFFFF, 16'h0001, 16'h8000, 16'hFFFE,
                         16'hABCD, 16'h0000, 16'hFFFF, 16'h0001}, 0);

    // Blend at scale zero: only the B black level remains
    load_settings(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, '1, '0,
                  OP_BLEND, MODE_PLAIN);
    send_quad(pick_quad(), 0);
    send_quad(pick_quad(), 0);

    // Random phases: new settings each phase, sender gaps cycled
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_random_settings(phase);
      for (int n = 0; n < QUADS_PER_PHASE; n++) begin
        // now and then let the pipeline run dry mid-phase
        if ($urandom_range(149) == 0) wait_for_drain();
        send_quad(pick_quad(), idle_pct_by_phase[phase % 3]);
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_quads == 0) begin
      $display("dual_pixel_raw_subframe_combine_core_test: done, clean");
    end else begin
      $display("dual_pixel_raw_subframe_combine_core_test: done, errors");
    end
    $finish;
  end

endmodule
